### rtl/setx_pkg.sv
package setx_pkg;

   localparam int ByteW      = 8;
   localparam int CsrIndexW  = 2;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = 1;
   localparam int QueueCntW  = 2;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_START_MARKER = 2'd0,
      CSR_END_MARKER   = 2'd1,
      CSR_ACK_CODE     = 2'd2,
      CSR_NACK_CODE    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_BAD_SUM = 2'd2,
      KIND_BAD_END = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      PH_HUNT = 5'b00001,
      PH_LEN  = 5'b00010,
      PH_DATA = 5'b00100,
      PH_CHK  = 5'b01000,
      PH_END  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [ByteW-1:0] start_marker;
      logic [ByteW-1:0] end_marker;
      logic [ByteW-1:0] ack_code;
      logic [ByteW-1:0] nack_code;
   } cfg_type;

   typedef struct packed {
      kind_type         kind;
      logic [ByteW-1:0] data;
      logic [ByteW-1:0] index;
   } evt_type;

   typedef struct packed {
      logic    valid;
      evt_type evt;
   } push_type;

   typedef struct packed {
      logic    valid;
      logic    full;
      evt_type evt;
   } qstat_type;

endpackage

### rtl/setx_front.sv
module setx_front #(
   parameter int MAX_PAYLOAD = 255
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [setx_pkg::ByteW-1:0]    req_rx_byte,
   input  setx_pkg::cfg_type             cfg,
   input  logic                          queue_full,
   output setx_pkg::push_type            push
);
   import setx_pkg::*;

   localparam logic [ByteW-1:0] MaxPayload = ByteW'(MAX_PAYLOAD);

   phase_type        phase_ff, phase_in;
   logic [ByteW-1:0] len_ff, len_in;
   logic [ByteW-1:0] sum_ff, sum_in;
   logic [ByteW-1:0] cnt_ff, cnt_in;
   logic [ByteW-1:0] cnt_next;
   logic             accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign cnt_next  = cnt_ff + 8'd1;

   always_comb begin
      phase_in       = phase_ff;
      len_in         = len_ff;
      sum_in         = sum_ff;
      cnt_in         = cnt_ff;
      push.valid     = 1'b0;
      push.evt.kind  = KIND_PAYLOAD;
      push.evt.data  = req_rx_byte;
      push.evt.index = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_LEN: begin
               len_in   = req_rx_byte;
               sum_in   = req_rx_byte;
               cnt_in   = '0;
               phase_in = (req_rx_byte != 8'd0) ? PH_DATA : PH_CHK;
            end
            PH_DATA: begin
               cnt_in = cnt_next;
               sum_in = sum_ff + req_rx_byte;
               if (cnt_next >= len_ff) begin
                  phase_in = PH_CHK;
               end
               if (cnt_ff < MaxPayload) begin
                  push.valid     = 1'b1;
                  push.evt.index = cnt_ff;
               end
            end
            PH_CHK: begin
               if (req_rx_byte == sum_ff) begin
                  phase_in = PH_END;
               end else begin
                  phase_in      = PH_HUNT;
                  push.valid    = 1'b1;
                  push.evt.kind = KIND_BAD_SUM;
               end
            end
            PH_END: begin
               phase_in      = PH_HUNT;
               push.valid    = 1'b1;
               push.evt.kind = (req_rx_byte == cfg.end_marker) ? KIND_ACCEPT : KIND_BAD_END;
            end
            default: begin
               phase_in = (req_rx_byte == cfg.start_marker) ? PH_LEN : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         len_ff   <= '0;
         sum_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### rtl/setx_queue.sv
module setx_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  setx_pkg::push_type    push,
   input  logic                  pop,
   output setx_pkg::qstat_type   stat
);
   import setx_pkg::*;

   evt_type                mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   cnt_ff, cnt_in;
   logic                   do_pop;

   assign stat.valid = (cnt_ff != '0);
   assign stat.full  = (cnt_ff == QueueCntW'(QueueDepth));
   assign stat.evt   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && stat.valid;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QueueCntW'(push.valid) - QueueCntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.evt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QueueCntW'(QueueDepth))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      !(push.valid && stat.full))
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      (push.valid && !do_pop) |=> stat.valid)
      else $error("pushed beat lost");

   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == cnt_ff[QueuePtrW-1:0])
      else $error("queue pointers disagree with count");

endmodule

### rtl/setx_back.sv
module setx_back (
   input  logic                          clock,
   input  logic                          reset,
   input  setx_pkg::qstat_type           stat,
   output logic                          pop,
   input  setx_pkg::cfg_type             cfg,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_out_kind,
   output logic [setx_pkg::ByteW-1:0]    rsp_out_byte,
   output logic [setx_pkg::ByteW-1:0]    rsp_out_index
);
   import setx_pkg::*;

   logic             valid_ff, valid_in;
   kind_type         kind_ff;
   logic [ByteW-1:0] byte_ff, byte_in;
   logic [ByteW-1:0] index_ff;

   assign pop      = stat.valid && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_comb begin
      unique case (stat.evt.kind)
         KIND_PAYLOAD: byte_in = stat.evt.data;
         KIND_ACCEPT:  byte_in = cfg.ack_code;
         default:      byte_in = cfg.nack_code;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= stat.evt.kind;
         byte_ff  <= byte_in;
         index_ff <= stat.evt.index;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_kind  = kind_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_out_index = index_ff;

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |-> !pop)
      else $error("output overwritten while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff != KIND_PAYLOAD) |-> (index_ff == '0))
      else $error("verdict carries nonzero index");

   assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("popped beat not presented");

endmodule

### rtl/stx_etx_frame_receiver_core.sv
// Framed byte receiver: hunt start marker, length, payload, checksum, end marker.
// Throughput: one byte per cycle while req_stall is low (queue not full); the front updates phase and sum per byte.
// Path: the event for an accepted byte is written into the queue, then popped into the output
// register that drives rsp_valid; while rsp_stall holds a beat, later events wait in the queue.
// A two-entry queue and an output register let input and output stall independently.
// Reset (synchronous, active high): hunting, counters and sum cleared, config registers to defaults.
module stx_etx_frame_receiver_core #(
   parameter int MAX_PAYLOAD = 255
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [setx_pkg::ByteW-1:0]        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_out_kind,
   output logic [setx_pkg::ByteW-1:0]        rsp_out_byte,
   output logic [setx_pkg::ByteW-1:0]        rsp_out_index,
   input  logic                              csr_we,
   input  logic [setx_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [setx_pkg::ByteW-1:0]        csr_wdata
);
   import setx_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   push_type  push;
   qstat_type stat;
   logic      pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_MARKER: cfg_in.start_marker = csr_wdata;
            CSR_END_MARKER:   cfg_in.end_marker   = csr_wdata;
            CSR_ACK_CODE:     cfg_in.ack_code     = csr_wdata;
            CSR_NACK_CODE:    cfg_in.nack_code    = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker <= 8'h02;
         cfg_ff.end_marker   <= 8'h03;
         cfg_ff.ack_code     <= 8'h06;
         cfg_ff.nack_code    <= 8'h15;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   setx_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_rx_byte(req_rx_byte),
      .cfg        (cfg_ff),
      .queue_full (stat.full),
      .push       (push)
   );

   setx_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .pop  (pop),
      .stat (stat)
   );

   setx_back u_back (
      .clock        (clock),
      .reset        (reset),
      .stat         (stat),
      .pop          (pop),
      .cfg          (cfg_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_index(rsp_out_index)
   );

endmodule
